FILE: hw/rtl/gif_lzw_code_stream_encoder_defines.svh
// ----------------------------------------------------------------------------
// GIF LZW encoder assertion macros
// Shared concurrent assertion forms; clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_CODE_STREAM_ENCODER_DEFINES_SVH
`define GIF_LZW_CODE_STREAM_ENCODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define GLZW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define GLZW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/glzw_pkg.sv
// ----------------------------------------------------------------------------
// glzw_pkg
// Types and fixed constants shared by the GIF LZW code-stream encoder.
// ----------------------------------------------------------------------------
package glzw_pkg;

	// Code space of the GIF LZW dictionary
	localparam int MAX_CODES = 4096;
	localparam int CODE_W    = 12;
	localparam int NC_W      = 13;
	localparam int CW_W      = 4;
	localparam int MAX_WIDTH = 12;

	// Codes one item can put out: prefix, clear, final prefix, end-of-information
	localparam int NUM_SLOTS = 4;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int SUMW_W    = 6;

	// Bit packer: up to seven pending bits plus one full-width code
	localparam int ACC_W     = 20;
	localparam int BITS_W    = 5;
	localparam int BYTES_W   = 3;

	// Codes of one item, lowest slot first
	typedef struct packed {
		logic [NUM_SLOTS-1:0][CODE_W-1:0] code;
		logic [NUM_SLOTS-1:0][CW_W-1:0]   width;
		logic [CNT_W-1:0]                 n;
		logic [SUMW_W-1:0]                sumw;
		logic                             flush;
	} bundle_t;

	// Matcher status seen by the input handshake
	typedef struct packed {
		logic busy_s1;
		logic clearing;
	} mt_status_t;

endpackage

FILE: hw/rtl/gif_lzw_code_stream_encoder.sv
// ----------------------------------------------------------------------------
// gif_lzw_code_stream_encoder
// GIF LZW code-stream encoder: palette indices in, packed code bytes out.
//
//   channel  dir  tdata                   tlast       tuser
//   s_*      in   [4:0] pixel, [7:5] 0    last_pixel  -
//   m_*      out  [7:0] out_byte          run_end     image_end
//
// A pixel goes through the dictionary read, then the hit/miss decision and
// write-back, which sets the next pixel's read address. Its codes wait in a
// one-item slot that frees as the packer takes them, one byte out per cycle
// while the output is not stalled. A packer still busy with an earlier item,
// or a stalled output, holds s_tready. After reset and every 2^EPOCH_BITS - 1
// restarts, 2^(12+PIXEL_BITS) tags (131072 by default) are zeroed, input held.
// ----------------------------------------------------------------------------
module gif_lzw_code_stream_encoder
	import glzw_pkg::*;
#(
	parameter int PIXEL_BITS = 5,
	parameter int EPOCH_BITS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [4:0] pixel, [7:5] zero
	input  logic       s_tlast,   // last_pixel
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // run_end
	output logic       m_tuser    // image_end
);

	mt_status_t status;
	logic       accept;
	logic       push;
	bundle_t    bundle;
	logic       slot_full;

	// Take a pixel when the lookup stage and code slot are free and no tag sweep runs
	assign s_tready = !status.busy_s1 && !status.clearing && !slot_full;
	assign accept   = s_tvalid && s_tready;

	glzw_matcher #(
		.PIXEL_BITS(PIXEL_BITS),
		.EPOCH_BITS(EPOCH_BITS)
	) u_matcher (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pixel     (s_tdata[PIXEL_BITS-1:0]),
		.last_pixel(s_tlast),
		.status    (status),
		.push      (push),
		.bundle    (bundle)
	);

	glzw_packer u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.bundle   (bundle),
		.slot_full(slot_full),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: hw/rtl/glzw_ram.sv
// ----------------------------------------------------------------------------
// glzw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module glzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/glzw_matcher.sv
// ----------------------------------------------------------------------------
// glzw_matcher
// Dictionary lookup and update: reads (prefix, pixel), decides hit or miss,
// writes the new child code back and hands the item's codes to the packer.
// An epoch tag per entry spares a restart any clearing until the epoch wraps.
// ----------------------------------------------------------------------------
`include "gif_lzw_code_stream_encoder_defines.svh"

module glzw_matcher
	import glzw_pkg::*;
#(
	parameter int PIXEL_BITS = 5,
	parameter int EPOCH_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [PIXEL_BITS-1:0] pixel,
	input  logic                  last_pixel,
	output mt_status_t            status,
	output logic                  push,
	output bundle_t               bundle
);

	localparam int ADDR_W  = CODE_W + PIXEL_BITS;
	localparam int DEPTH   = 1 << ADDR_W;
	localparam int ENTRY_W = EPOCH_BITS + CODE_W;

	localparam logic [CODE_W-1:0]     CLEAR_CODE  = CODE_W'(1 << PIXEL_BITS);
	localparam logic [CODE_W-1:0]     EOI_CODE    = CODE_W'((1 << PIXEL_BITS) + 1);
	localparam logic [NC_W-1:0]       FIRST_CODE  = NC_W'((1 << PIXEL_BITS) + 2);
	localparam logic [NC_W-1:0]       FULL_CODE   = NC_W'(MAX_CODES);
	localparam logic [CW_W-1:0]       START_WIDTH = CW_W'(PIXEL_BITS + 1);
	localparam logic [CW_W-1:0]       TOP_WIDTH   = CW_W'(MAX_WIDTH);
	localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = {EPOCH_BITS{1'b1}};
	localparam logic [EPOCH_BITS-1:0] EPOCH_ONE   = EPOCH_BITS'(1);
	localparam logic [ADDR_W-1:0]     ADDR_LAST   = {ADDR_W{1'b1}};

	// Stage 1: item waiting for its dictionary read
	logic                  v_s1;
	logic [PIXEL_BITS-1:0] pixel_s1;
	logic                  last_s1;

	// Encoder state
	logic [CODE_W-1:0]     prefix_q;
	logic [NC_W-1:0]       next_code_q;
	logic [CW_W-1:0]       width_q;
	logic                  in_image_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic                  clearing_q;
	logic [ADDR_W-1:0]     clr_addr_q;

	// Memory port signals
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic [ENTRY_W-1:0]    ram_rdata;
	logic [EPOCH_BITS-1:0] rd_tag;
	logic [CODE_W-1:0]     rd_code;

	// Decision
	logic                  hit;
	logic                  miss;
	logic                  full;
	logic                  add_en;
	logic                  restart;
	logic [NC_W-1:0]       nc_inc;
	logic                  grow;
	logic [CW_W-1:0]       width_add;
	logic [CW_W-1:0]       fin_width;
	logic [CODE_W-1:0]     prefix_n;
	logic [1:0]            n_main;
	bundle_t               bnd;

	glzw_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_dict (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr({prefix_q, pixel}),
		.rdata(ram_rdata)
	);

	assign rd_tag  = ram_rdata[ENTRY_W-1:CODE_W];
	assign rd_code = ram_rdata[CODE_W-1:0];

	// Hit only on entries written since the last restart
	assign hit       = in_image_q && (rd_tag == epoch_q);
	assign miss      = in_image_q && !hit;
	assign full      = (next_code_q == FULL_CODE);
	assign add_en    = v_s1 && miss && !full;
	assign restart   = v_s1 && (!in_image_q || (miss && full));
	assign nc_inc    = next_code_q + NC_W'(1);
	assign grow      = (nc_inc > (NC_W'(1) << width_q)) && (width_q < TOP_WIDTH);
	assign width_add = grow ? width_q + CW_W'(1) : width_q;
	assign prefix_n  = hit ? rd_code : CODE_W'(pixel_s1);

	always_comb begin
		if (restart) begin
			fin_width = START_WIDTH;
		end else if (add_en) begin
			fin_width = width_add;
		end else begin
			fin_width = width_q;
		end
	end

	// Write back a new entry, or sweep tags to zero while clearing
	assign ram_we    = add_en || clearing_q;
	assign ram_waddr = clearing_q ? clr_addr_q : {prefix_q, pixel_s1};
	assign ram_wdata = clearing_q ? '0 : {epoch_q, next_code_q[CODE_W-1:0]};

	// Assemble the codes of this item in output order
	always_comb begin
		bnd    = '0;
		n_main = 2'd0;
		if (!in_image_q) begin
			n_main         = 2'd1;
			bnd.code[0]    = CLEAR_CODE;
			bnd.width[0]   = START_WIDTH;
		end else if (miss) begin
			bnd.code[0]    = prefix_q;
			bnd.width[0]   = width_q;
			if (full) begin
				n_main       = 2'd2;
				bnd.code[1]  = CLEAR_CODE;
				bnd.width[1] = width_q;
			end else begin
				n_main       = 2'd1;
			end
		end
		if (last_s1) begin
			case (n_main)
				2'd0: begin
					bnd.code[0]  = prefix_n;
					bnd.width[0] = fin_width;
					bnd.code[1]  = EOI_CODE;
					bnd.width[1] = fin_width;
				end
				2'd1: begin
					bnd.code[1]  = prefix_n;
					bnd.width[1] = fin_width;
					bnd.code[2]  = EOI_CODE;
					bnd.width[2] = fin_width;
				end
				2'd2: begin
					bnd.code[2]  = prefix_n;
					bnd.width[2] = fin_width;
					bnd.code[3]  = EOI_CODE;
					bnd.width[3] = fin_width;
				end
				default: begin
					bnd.code[0]  = prefix_n;
					bnd.width[0] = fin_width;
				end
			endcase
		end
		bnd.n     = CNT_W'(n_main) + (last_s1 ? CNT_W'(2) : CNT_W'(0));
		bnd.sumw  = SUMW_W'(bnd.width[0]) + SUMW_W'(bnd.width[1])
			+ SUMW_W'(bnd.width[2]) + SUMW_W'(bnd.width[3]);
		bnd.flush = last_s1;
	end

	assign push            = v_s1 && (bnd.n != '0);
	assign bundle          = bnd;
	assign status.busy_s1  = v_s1;
	assign status.clearing = clearing_q;

	// Capture the accepted item for the read cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			last_s1  <= last_pixel;
		end
	end

	// Advance prefix, code counter, width and epoch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q    <= '0;
			next_code_q <= FIRST_CODE;
			width_q     <= START_WIDTH;
			in_image_q  <= 1'b0;
			epoch_q     <= '0;
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
		end else begin
			if (v_s1) begin
				prefix_q   <= prefix_n;
				in_image_q <= !last_s1;
			end
			if (restart) begin
				next_code_q <= FIRST_CODE;
				width_q     <= START_WIDTH;
				if (epoch_q == EPOCH_MAX) begin
					epoch_q    <= EPOCH_ONE;
					clearing_q <= 1'b1;
					clr_addr_q <= '0;
				end else begin
					epoch_q <= epoch_q + EPOCH_ONE;
				end
			end else if (add_en) begin
				next_code_q <= nc_inc;
				width_q     <= width_add;
			end
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == ADDR_LAST) begin
					clearing_q <= 1'b0;
				end
			end
		end
	end

	`GLZW_ASSERT_NOW(a_width_range, 1'b1,
		(width_q >= START_WIDTH) && (width_q <= TOP_WIDTH), "code width out of range")
	`GLZW_ASSERT_NOW(a_code_range, 1'b1,
		(next_code_q >= FIRST_CODE) && (next_code_q <= FULL_CODE), "next code out of range")
	`GLZW_ASSERT_NOW(a_no_add_in_sweep, v_s1, !clearing_q, "item evaluated during tag sweep")
	`GLZW_ASSERT_NEXT(a_restart_epoch, restart, epoch_q != '0, "restart left epoch at zero")

endmodule

FILE: hw/rtl/glzw_packer.sv
// ----------------------------------------------------------------------------
// glzw_packer
// Packs variable-width codes LSB first into bytes, one code in and one byte
// out per cycle while the output is not stalled, and marks the last byte of each item and of the image.
// ----------------------------------------------------------------------------
`include "gif_lzw_code_stream_encoder_defines.svh"

module glzw_packer
	import glzw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  bundle_t    bundle,
	output logic       slot_full,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic       m_tuser
);

	// Slot: one item's codes waiting for the packer
	bundle_t                          slot_q;
	logic                             slot_v_q;

	// Working item
	logic [NUM_SLOTS-1:0][CODE_W-1:0] wcode_q;
	logic [NUM_SLOTS-1:0][CW_W-1:0]   wwidth_q;
	logic [CNT_W-1:0]                 wn_q;
	logic                             wflush_q;
	logic [BYTES_W-1:0]               bytes_left_q;

	// Bit accumulator
	logic [ACC_W-1:0]                 acc_q;
	logic [BITS_W-1:0]                cnt_q;

	// Output register
	logic                             m_valid_q;
	logic [7:0]                       m_data_q;
	logic                             m_last_q;
	logic                             m_user_q;

	logic                             busy;
	logic                             load;
	logic                             out_free;
	logic                             emit;
	logic                             final_byte;
	logic                             merge;
	logic [ACC_W-1:0]                 acc_a;
	logic [BITS_W-1:0]                cnt_a;
	logic [ACC_W-1:0]                 acc_n;
	logic [BITS_W-1:0]                cnt_n;
	logic [SUMW_W-1:0]                total_bits;

	assign busy     = (wn_q != '0) || (bytes_left_q != '0);
	assign load     = slot_v_q && !busy;
	assign out_free = !m_valid_q || m_tready;

	// Emit a full byte, or the padded tail once every code is in
	assign emit = (bytes_left_q != '0) && out_free
		&& ((cnt_q >= BITS_W'(8)) || ((wn_q == '0) && wflush_q));
	assign final_byte = (bytes_left_q == BYTES_W'(1));

	always_comb begin
		acc_a = acc_q;
		cnt_a = cnt_q;
		if (emit) begin
			acc_a = acc_q >> 8;
			cnt_a = (cnt_q >= BITS_W'(8)) ? cnt_q - BITS_W'(8) : '0;
		end
	end

	// Merge the next code above the pending bits
	assign merge = (wn_q != '0) && (cnt_a < BITS_W'(8));
	assign acc_n = acc_a | (ACC_W'(wcode_q[0]) << cnt_a[2:0]);
	assign cnt_n = cnt_a + BITS_W'(wwidth_q[0]);

	// Byte count of a new item: pending bits plus its codes, rounded up on flush
	assign total_bits = SUMW_W'(cnt_q[2:0]) + slot_q.sumw
		+ (slot_q.flush ? SUMW_W'(7) : SUMW_W'(0));

	// Slot fill and drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_v_q <= 1'b0;
		end else if (push) begin
			slot_v_q <= 1'b1;
		end else if (load) begin
			slot_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q <= bundle;
		end
	end

	// Working item: take codes from the slot, shift them out one by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wn_q         <= '0;
			wflush_q     <= 1'b0;
			bytes_left_q <= '0;
			acc_q        <= '0;
			cnt_q        <= '0;
		end else if (load) begin
			wn_q         <= slot_q.n;
			wflush_q     <= slot_q.flush;
			bytes_left_q <= total_bits[SUMW_W-1:3];
		end else begin
			if (emit) begin
				bytes_left_q <= bytes_left_q - BYTES_W'(1);
			end
			if (emit && final_byte && wflush_q) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else if (merge) begin
				acc_q <= acc_n;
				cnt_q <= cnt_n;
				wn_q  <= wn_q - CNT_W'(1);
			end else begin
				acc_q <= acc_a;
				cnt_q <= cnt_a;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			wcode_q  <= slot_q.code;
			wwidth_q <= slot_q.width;
		end else if (merge) begin
			for (int i = 0; i < NUM_SLOTS - 1; i++) begin
				wcode_q[i]  <= wcode_q[i+1];
				wwidth_q[i] <= wwidth_q[i+1];
			end
			wcode_q[NUM_SLOTS-1]  <= '0;
			wwidth_q[NUM_SLOTS-1] <= '0;
		end
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= acc_q[7:0];
			m_last_q <= final_byte;
			m_user_q <= final_byte && wflush_q;
		end
	end

	// Slot counts as free in the cycle it hands its item to the packer
	assign slot_full = slot_v_q && !load;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign m_tlast   = m_last_q;
	assign m_tuser   = m_user_q;

	`GLZW_ASSERT_NOW(a_idle_cnt, !busy, cnt_q < BITS_W'(8), "pending bits reach a byte when idle")
	`GLZW_ASSERT_NOW(a_push_free, push, !slot_v_q, "item pushed onto a full slot")
	`GLZW_ASSERT_NOW(a_merge_fits, merge, cnt_n <= BITS_W'(19), "accumulator overflow on merge")
	`GLZW_ASSERT_NEXT(a_flush_clean, emit && final_byte && wflush_q, cnt_q == '0,
		"bits left over after image flush")

endmodule

FILE: test/gif_lzw_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_stream_checker
// Watches both stream channels of the GIF LZW encoder. Every pixel transfer
// is run through a local LZW encoder, and its bytes are queued. Every output
// transfer is compared field by field with the oldest queued byte.
// ----------------------------------------------------------------------------
module gif_lzw_stream_checker
	import glzw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [4:0] pixel, [7:5] zero
	input  logic       s_tlast,   // last_pixel
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_byte
	input  logic       m_tlast,   // run_end
	input  logic       m_tuser,   // image_end
	output int         fail_count,
	output int         pending,
	output int         bytes_checked,
	output int         table_full_count
);

	localparam int PIXEL_BITS = 5;
	localparam logic [CODE_W-1:0] CLEAR_CODE = CODE_W'(1 << PIXEL_BITS);
	localparam logic [CODE_W-1:0] EOI_CODE   = CLEAR_CODE + 1'b1;
	localparam logic [NC_W-1:0]   FIRST_FREE = NC_W'(CLEAR_CODE) + 2'd2;
	localparam logic [CW_W-1:0]   START_W    = CW_W'(PIXEL_BITS + 1);
	localparam int                PRINT_CAP  = 100;

	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       image_end;
	} code_byte_t;

	// Encoder state: a missing key is an empty dictionary entry
	logic [CODE_W-1:0] child_of [int];
	logic [CODE_W-1:0] prefix    = '0;
	logic [NC_W-1:0]   next_free = FIRST_FREE;
	logic [CW_W-1:0]   width     = START_W;
	logic [31:0]       bit_acc   = '0;
	int unsigned       bit_cnt   = 0;
	bit                in_image  = 1'b0;

	code_byte_t item_q[$];
	code_byte_t expected_q[$];

	int n_fail     = 0;
	int n_pending  = 0;
	int n_checked  = 0;
	int n_full     = 0;

	assign fail_count       = n_fail;
	assign pending          = n_pending;
	assign bytes_checked    = n_checked;
	assign table_full_count = n_full;

	task report_mismatch(input string msg);
		if (n_fail < PRINT_CAP)
			$display("[%0t] stream mismatch: %s", $time, msg);
		n_fail++;
	endtask

	// Pack one code LSB first and release every whole byte
	function void emit_code(input logic [CODE_W-1:0] code, input logic [CW_W-1:0] w);
		bit_acc |= 32'(code) << bit_cnt;
		bit_cnt += w;
		while (bit_cnt >= 8) begin
			item_q.push_back({bit_acc[7:0], 2'b00});
			bit_acc >>= 8;
			bit_cnt -= 8;
		end
	endfunction

	function void restart_table();
		child_of.delete();
		next_free = FIRST_FREE;
		width     = START_W;
	endfunction

	// Encode one pixel and queue the bytes it completes
	function void encode_pixel(input logic [4:0] pix, input logic last);
		logic [PIXEL_BITS-1:0] k;
		int                    key;
		k = pix[PIXEL_BITS-1:0];
		item_q.delete();
		if (!in_image) begin
			restart_table();
			emit_code(CLEAR_CODE, width);
			prefix   = CODE_W'(k);
			in_image = 1'b1;
		end else begin
			key = int'({prefix, k});
			if (child_of.exists(key)) begin
				prefix = child_of[key];
			end else begin
				emit_code(prefix, width);
				if (next_free < NC_W'(MAX_CODES)) begin
					child_of[key] = next_free[CODE_W-1:0];
					next_free++;
					if (next_free > (1 << width) && width < MAX_WIDTH)
						width++;
				end else begin
					// table full: clear at the current width, then start over
					emit_code(CLEAR_CODE, width);
					restart_table();
					n_full++;
				end
				prefix = CODE_W'(k);
			end
		end
		// close the image: final prefix, end-of-information, padded byte
		if (last) begin
			emit_code(prefix, width);
			emit_code(EOI_CODE, width);
			if (bit_cnt > 0)
				item_q.push_back({bit_acc[7:0], 2'b00});
			bit_acc  = '0;
			bit_cnt  = 0;
			in_image = 1'b0;
		end
		if (item_q.size() > 0) begin
			item_q[$].run_end   = 1'b1;
			item_q[$].image_end = last;
		end
		foreach (item_q[i])
			expected_q.push_back(item_q[i]);
	endfunction

	// Predict on input transfers, compare on output transfers
	always @(posedge clk) begin
		code_byte_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				encode_pixel(s_tdata[4:0], s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("byte %02h with none expected", m_tdata));
				end else begin
					want = expected_q.pop_front();
					n_checked++;
					if (m_tdata !== want.data)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							m_tdata, want.data));
					if (m_tlast !== want.run_end)
						report_mismatch($sformatf("run_end %b, expected %b on byte %02h",
							m_tlast, want.run_end, want.data));
					if (m_tuser !== want.image_end)
						report_mismatch($sformatf("image_end %b, expected %b on byte %02h",
							m_tuser, want.image_end, want.data));
				end
			end
			n_pending = expected_q.size();
		end
	end

endmodule

FILE: test/tb_gif_lzw_code_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gif_lzw_code_stream_encoder
// Drives palette indices into the GIF LZW encoder: a few short directed
// images, then random images under four idling patterns, some long enough to
// widen the codes. The checker beside the block predicts the bytes.
// ----------------------------------------------------------------------------
module tb_gif_lzw_code_stream_encoder;

	localparam int CLK_PERIOD  = 8;
	// most of the slowest run is the tag sweep after reset
	localparam int LIMIT_NS    = 1_500_000 * CLK_PERIOD;
	localparam int PHASE_ITEMS = 48;
	localparam int DRAIN_CYCLES = 40;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int pixels_sent    = 0;
	int images_sent    = 0;

	int fail_count;
	int pending;
	int bytes_checked;
	int table_full_count;

	always #(CLK_PERIOD / 2) clk = ~clk;

	gif_lzw_code_stream_encoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	gif_lzw_stream_checker u_stream_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tlast          (s_tlast),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tlast          (m_tlast),
		.m_tuser          (m_tuser),
		.fail_count       (fail_count),
		.pending          (pending),
		.bytes_checked    (bytes_checked),
		.table_full_count (table_full_count)
	);

	// Stall the output side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Hold one pixel until its transfer, after a random gap
	task automatic send_pixel(input logic [4:0] pix, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, pix};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
		if (last)
			images_sent++;
	endtask

	// Random image: mostly short, now and then long; narrow palettes give hits
	task automatic send_random_image(input int max_len);
		int len;
		int alpha;
		int base;
		len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 24);
		if (len > max_len)
			len = max_len;
		case ($urandom_range(2))
			0: alpha = 2;
			1: alpha = 6;
			default: alpha = 32;
		endcase
		base = $urandom_range(31);
		for (int i = 0; i < len; i++)
			send_pixel(5'((base + $urandom_range(alpha - 1)) % 32), i == len - 1);
	endtask

	initial begin
		int phase_start;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		m_tready <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// single-pixel images at both ends of the palette
		send_pixel(5'd0, 1'b1);
		send_pixel(5'd31, 1'b1);
		// one colour repeated: dictionary hits build longer strings
		repeat (4) send_pixel(5'd31, 1'b0);
		send_pixel(5'd31, 1'b1);
		// mixed image, alternating bit patterns
		send_pixel(5'd0, 1'b0);
		send_pixel(5'd0, 1'b0);
		send_pixel(5'd31, 1'b0);
		send_pixel(5'd0, 1'b0);
		send_pixel(5'd31, 1'b0);
		send_pixel(5'd21, 1'b0);
		send_pixel(5'd10, 1'b1);
		// two-pixel image
		send_pixel(5'd5, 1'b0);
		send_pixel(5'd5, 1'b1);

		// random images under each idling pattern
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			phase_start = pixels_sent;
			while (pixels_sent - phase_start < PHASE_ITEMS)
				send_random_image(PHASE_ITEMS - (pixels_sent - phase_start));
		end

		// drain and watch for stray bytes
		s_tvalid <= 1'b0;
		recv_stall_pct = 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d pixels in %0d images, %0d code-stream bytes compared.",
			pixels_sent, images_sent, bytes_checked);
		$display("Table overflows seen: %0d; idling: none, sender, receiver, both.",
			table_full_count);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule
